>>> rtl/pttt_pkg.sv
package pttt_pkg;

	// Table geometry.
	localparam int MAX_TASKS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W       = $clog2(MAX_TASKS + 1);
	localparam int NF_W        = $clog2(MAX_RESULTS + 1);

	// Field widths.
	localparam int ACT_W  = 3;
	localparam int KEY_W  = 16;
	localparam int TIME_W = 32;
	localparam int STAT_W = 2;

	// Request kinds.
	localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	// One task entry.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] last_run;
		logic              enabled;
	} tbl_entry_t;

	// Write request into the table: a whole entry, the flag alone or the last-run alone.
	typedef struct packed {
		logic             we_entry;
		logic             we_en;
		logic             we_last;
		logic [IDX_W-1:0] addr;
		tbl_entry_t       data;
	} tbl_wr_t;

	// Outcome of the shared compare unit for the entry under the scan pointer.
	typedef struct packed {
		logic key_eq;
		logic due;
	} cmp_res_t;

endpackage

>>> rtl/periodic_task_timer_table.sv
// Channel  | Direction | Handshake              | Contents
// s_axis   | in        | s_axis_tvalid/tready   | tuser: action; tdata: key, interval, flag, now
// m_axis   | out       | m_axis_tvalid/tready   | tuser: fired flag; tdata: status, fired key
//
// A request is taken in, then the table entries are visited one after another through the
// single read port and the shared compare unit, then the end of the table is seen and the
// final result is sent. A remove closes the gap by copying each later entry down one place
// in place of the rest of the scan, so it takes no longer than a full scan.
// Reset empties the table at once by clearing the task count; entries need no clearing.
// A full output register stalls the scan before any further result is produced.
module periodic_task_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // task_key[15:0], interval_ms[47:16],
	                                   // start_enabled[48], now_ms[80:49], zero fill
	input  logic [2:0]  s_axis_tuser,  // action[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status[1:0], fired_key[17:2], zero fill
	output logic [0:0]  m_axis_tuser,  // fired_valid[0]
	output logic        m_axis_tlast
);
	import pttt_pkg::*;

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_FINAL = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [NF_W-1:0]   nfire_q, nfire_d;
	logic              pend_q, pend_d;
	logic [KEY_W-1:0]  pend_key_q, pend_key_d;
	logic [STAT_W-1:0] res_status_q, res_status_d;

	logic [ACT_W-1:0]  act_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] interval_q;
	logic              start_en_q;
	logic [TIME_W-1:0] now_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_fired_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_last_q;

	logic              emit;
	logic [STAT_W-1:0] emit_status;
	logic              emit_fired;
	logic [KEY_W-1:0]  emit_key;
	logic              emit_last;

	logic              in_acc;
	logic              slot_free;
	logic              scan_end;
	logic [CNT_W-1:0]  idx_next;
	logic [IDX_W-1:0]  rd_addr;
	tbl_wr_t           wr;
	tbl_entry_t        rd_data;
	cmp_res_t          cmp;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !out_valid_q || m_axis_tready;
	assign scan_end  = (idx_q >= count_q);
	assign idx_next  = idx_q + CNT_W'(1);
	assign rd_addr   = (state_q == S_SHIFT) ? idx_next[IDX_W-1:0] : idx_q[IDX_W-1:0];

	pttt_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pttt_unit u_unit (
		.entry (rd_data),
		.key   (key_q),
		.now   (now_q),
		.res   (cmp)
	);

	// Sequencer: one table entry is visited per cycle, unless a tick is held by a full output register.
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		count_d      = count_q;
		nfire_d      = nfire_q;
		pend_d       = pend_q;
		pend_key_d   = pend_key_q;
		res_status_d = res_status_q;
		wr           = '0;
		emit         = 1'b0;
		emit_status  = STAT_OK;
		emit_fired   = 1'b0;
		emit_key     = '0;
		emit_last    = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_SCAN;
					idx_d   = '0;
					nfire_d = '0;
					pend_d  = 1'b0;
				end
			end
			S_SCAN: begin
				case (act_q)
					ACT_ADD: begin
						if (count_q >= CNT_W'(MAX_TASKS)) begin
							res_status_d = STAT_FULL;
							state_d      = S_FINAL;
						end else if (scan_end) begin
							wr.we_entry          = 1'b1;
							wr.addr              = count_q[IDX_W-1:0];
							wr.data.key          = key_q;
							wr.data.interval     = interval_q;
							wr.data.last_run     = '0;
							wr.data.enabled      = start_en_q;
							count_d              = count_q + CNT_W'(1);
							res_status_d         = STAT_OK;
							state_d              = S_FINAL;
						end else if (cmp.key_eq) begin
							res_status_d = STAT_DUPLICATE;
							state_d      = S_FINAL;
						end else begin
							idx_d = idx_next;
						end
					end
					ACT_REMOVE: begin
						if (scan_end) begin
							res_status_d = STAT_NOT_FOUND;
							state_d      = S_FINAL;
						end else if (cmp.key_eq) begin
							state_d = S_SHIFT;
						end else begin
							idx_d = idx_next;
						end
					end
					ACT_ENABLE, ACT_DISABLE: begin
						if (scan_end) begin
							res_status_d = STAT_NOT_FOUND;
							state_d      = S_FINAL;
						end else if (cmp.key_eq) begin
							wr.we_en        = 1'b1;
							wr.addr         = idx_q[IDX_W-1:0];
							wr.data.enabled = (act_q == ACT_ENABLE);
							res_status_d    = STAT_OK;
							state_d         = S_FINAL;
						end else begin
							idx_d = idx_next;
						end
					end
					ACT_TICK: begin
						if (scan_end || nfire_q == NF_W'(MAX_RESULTS)) begin
							res_status_d = STAT_OK;
							state_d      = S_FINAL;
						end else if (cmp.due) begin
							// The previous fire goes out only once another one is known to follow.
							if (!pend_q || slot_free) begin
								emit          = pend_q;
								emit_fired    = 1'b1;
								emit_key      = pend_key_q;
								wr.we_last       = 1'b1;
								wr.addr          = idx_q[IDX_W-1:0];
								wr.data.last_run = now_q;
								pend_d        = 1'b1;
								pend_key_d    = rd_data.key;
								nfire_d       = nfire_q + NF_W'(1);
								idx_d         = idx_next;
							end
						end else begin
							idx_d = idx_next;
						end
					end
					default: begin
						res_status_d = STAT_OK;
						state_d      = S_FINAL;
					end
				endcase
			end
			S_SHIFT: begin
				// Close the gap: copy the following entry down one place.
				if (idx_next < count_q) begin
					wr.we_entry = 1'b1;
					wr.addr     = idx_q[IDX_W-1:0];
					wr.data     = rd_data;
					idx_d       = idx_next;
				end else begin
					count_d      = count_q - CNT_W'(1);
					res_status_d = STAT_OK;
					state_d      = S_FINAL;
				end
			end
			S_FINAL: begin
				if (slot_free) begin
					emit        = 1'b1;
					emit_status = res_status_q;
					emit_fired  = (act_q == ACT_TICK) && pend_q;
					emit_key    = emit_fired ? pend_key_q : '0;
					emit_last   = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			nfire_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			nfire_q <= nfire_d;
			pend_q  <= pend_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, pending fire and output register payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q      <= s_axis_tuser;
			key_q      <= s_axis_tdata[15:0];
			interval_q <= s_axis_tdata[47:16];
			start_en_q <= s_axis_tdata[48];
			now_q      <= s_axis_tdata[80:49];
		end
		pend_key_q   <= pend_key_d;
		res_status_q <= res_status_d;
		if (emit) begin
			out_status_q <= emit_status;
			out_fired_q  <= emit_fired;
			out_key_q    <= emit_key;
			out_last_q   <= emit_last;
		end
	end

	assign s_axis_tready   = (state_q == S_IDLE);
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'd0, out_key_q, out_status_q};
	assign m_axis_tuser[0] = out_fired_q;
	assign m_axis_tlast    = out_last_q;

	// The task count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");

	// A fired task is always reported with status ok.
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[1:0] == STAT_OK)
		else $error("fired result with non-ok status");

	// A result that names no task carries a zero key.
	a_nofire_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[17:2] == '0)
		else $error("non-fire result with a key");

	// A request taken in always starts the scan in the next cycle.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == S_SCAN && idx_q == '0)
		else $error("accepted request did not start a scan");

	// Only a tick produces a result without the last mark.
	a_not_last_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> act_q == ACT_TICK && m_axis_tuser[0])
		else $error("intermediate result outside a tick");

endmodule

>>> rtl/pttt_table.sv
module pttt_table (
	input  logic                          clk,
	input  pttt_pkg::tbl_wr_t             wr,
	input  logic [pttt_pkg::IDX_W-1:0]    rd_addr,
	output pttt_pkg::tbl_entry_t          rd_data
);
	import pttt_pkg::*;

	logic [KEY_W-1:0]  key_q      [MAX_TASKS];
	logic [TIME_W-1:0] interval_q [MAX_TASKS];
	logic [TIME_W-1:0] last_run_q [MAX_TASKS];
	logic              enabled_q  [MAX_TASKS];

	// Single write port; the flag and the last-run time can be written on their own.
	always_ff @(posedge clk) begin
		if (wr.we_entry) begin
			key_q[wr.addr]      <= wr.data.key;
			interval_q[wr.addr] <= wr.data.interval;
			last_run_q[wr.addr] <= wr.data.last_run;
			enabled_q[wr.addr]  <= wr.data.enabled;
		end else begin
			if (wr.we_en) begin
				enabled_q[wr.addr] <= wr.data.enabled;
			end
			if (wr.we_last) begin
				last_run_q[wr.addr] <= wr.data.last_run;
			end
		end
	end

	// Single read port at the address chosen by the sequencer.
	always_comb begin
		rd_data.key      = key_q[rd_addr];
		rd_data.interval = interval_q[rd_addr];
		rd_data.last_run = last_run_q[rd_addr];
		rd_data.enabled  = enabled_q[rd_addr];
	end

endmodule

>>> rtl/pttt_unit.sv
module pttt_unit (
	input  pttt_pkg::tbl_entry_t          entry,
	input  logic [pttt_pkg::KEY_W-1:0]    key,
	input  logic [pttt_pkg::TIME_W-1:0]   now,
	output pttt_pkg::cmp_res_t            res
);
	import pttt_pkg::*;

	logic [TIME_W-1:0] elapsed;

	// Elapsed time wraps modulo the word width, as the timer does.
	assign elapsed    = now - entry.last_run;
	assign res.key_eq = (entry.key == key);
	assign res.due    = entry.enabled && (elapsed >= entry.interval);

endmodule

>>> dv/periodic_task_timer_table_test.sv
module periodic_task_timer_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pttt_pkg::*;

	// Action codes that the block does not define and must ignore.
	localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = ACT_TICK + 3'd1;
	localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = '1;

	// One result as the block should send it.
	typedef struct {
		logic [STAT_W-1:0] status;
		logic              fired;
		logic [KEY_W-1:0]  key;
		logic              last;
	} fire_result_t;

	// Keeps its own copy of the task table and the results still owed by the block.
	class timer_table_scoreboard;
		bit [KEY_W-1:0]  tab_key      [MAX_TASKS];
		bit [TIME_W-1:0] tab_interval [MAX_TASKS];
		bit [TIME_W-1:0] tab_last_run [MAX_TASKS];
		bit              tab_enabled  [MAX_TASKS];
		int              tab_count;
		fire_result_t    owed_q[$];
		int              errors;

		function int find_key(input bit [KEY_W-1:0] key);
			for (int i = 0; i < tab_count; i++)
				if (tab_key[i] == key)
					return i;
			return -1;
		endfunction

		function void owe(input logic [STAT_W-1:0] st, input logic fired,
				input logic [KEY_W-1:0] key, input logic last);
			fire_result_t r;
			r.status = st;
			r.fired  = fired;
			r.key    = key;
			r.last   = last;
			owed_q.push_back(r);
		endfunction

		// Applies one accepted request to the table and queues what it should produce.
		function void note_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
				input logic [TIME_W-1:0] interval, input logic en, input logic [TIME_W-1:0] now);
			int              idx;
			int              n;
			bit [TIME_W-1:0] elapsed;
			fire_result_t    tail;
			case (act)
				ACT_ADD: begin
					if (tab_count >= MAX_TASKS) begin
						owe(STAT_FULL, 1'b0, '0, 1'b1);
					end else if (find_key(key) >= 0) begin
						owe(STAT_DUPLICATE, 1'b0, '0, 1'b1);
					end else begin
						tab_key[tab_count]      = key;
						tab_interval[tab_count] = interval;
						tab_last_run[tab_count] = '0;
						tab_enabled[tab_count]  = en;
						tab_count++;
						owe(STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				ACT_REMOVE: begin
					idx = find_key(key);
					if (idx < 0) begin
						owe(STAT_NOT_FOUND, 1'b0, '0, 1'b1);
					end else begin
						// Later entries move down one place to keep the order.
						for (int i = idx; i + 1 < tab_count; i++) begin
							tab_key[i]      = tab_key[i + 1];
							tab_interval[i] = tab_interval[i + 1];
							tab_last_run[i] = tab_last_run[i + 1];
							tab_enabled[i]  = tab_enabled[i + 1];
						end
						tab_count--;
						owe(STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				ACT_ENABLE, ACT_DISABLE: begin
					idx = find_key(key);
					if (idx < 0) begin
						owe(STAT_NOT_FOUND, 1'b0, '0, 1'b1);
					end else begin
						tab_enabled[idx] = (act == ACT_ENABLE);
						owe(STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				ACT_TICK: begin
					n = 0;
					for (int i = 0; i < tab_count && n < MAX_RESULTS; i++) begin
						elapsed = now - tab_last_run[i];
						if (tab_enabled[i] && elapsed >= tab_interval[i]) begin
							owe(STAT_OK, 1'b1, tab_key[i], 1'b0);
							tab_last_run[i] = now;
							n++;
						end
					end
					if (n == 0) begin
						owe(STAT_OK, 1'b0, '0, 1'b1);
					end else begin
						tail = owed_q.pop_back();
						tail.last = 1'b1;
						owed_q.push_back(tail);
					end
				end
				default: begin
					owe(STAT_OK, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		// Compares one accepted result with the oldest one owed.
		function void check_result(input logic [STAT_W-1:0] st, input logic fired,
				input logic [KEY_W-1:0] key, input logic last);
			fire_result_t want;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d fired %0b key %h last %0b",
						st, fired, key, last);
				return;
			end
			want = owed_q.pop_front();
			if (want.status !== st || want.fired !== fired || want.key !== key ||
					want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d fired %0b key %h last %0b, %s",
						want.status, want.fired, want.key, want.last,
						$sformatf("got status %0d fired %0b key %h last %0b",
						st, fired, key, last));
			end
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;  // task_key[15:0], interval_ms[47:16],
	                            // start_enabled[48], now_ms[80:49], zero fill
	logic [2:0]  s_axis_tuser;  // action[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // status[1:0], fired_key[17:2], zero fill
	logic [0:0]  m_axis_tuser;  // fired_valid[0]
	logic        m_axis_tlast;

	timer_table_scoreboard sb;
	logic            hold_rx   = 1'b0;
	int              recv_idle = 49;
	int              send_idle = 38;
	int              useful_count;
	bit [TIME_W-1:0] clock_ms;

	periodic_task_timer_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Give up well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Result side: check every accepted result and choose the next ready at random.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[1:0], m_axis_tuser[0], m_axis_tdata[17:2],
				m_axis_tlast);
		m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle);
	end

	// Offers one request, with a random gap first, and waits until it is taken.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] interval, input logic en, input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {7'd0, now, en, interval, key};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(act, key, interval, en, now);
		if (act <= ACT_TICK)
			useful_count++;
	endtask

	// Holds the result side off for a number of cycles in a process of its own.
	task automatic hold_receiver(input int cycles);
		fork
			begin
				hold_rx <= 1'b1;
				repeat (cycles) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
	endtask

	// Mostly a small pool of keys so that duplicates and hits are common.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(7) == 0)
			return KEY_W'($urandom_range(16'hFFFF));
		return KEY_W'($urandom_range(31));
	endfunction

	// A key that is in the table most of the time, any key otherwise.
	function automatic logic [KEY_W-1:0] table_key();
		if (sb.tab_count > 0 && $urandom_range(4) != 0)
			return sb.tab_key[$urandom_range(sb.tab_count - 1)];
		return pick_key();
	endfunction

	function automatic logic [TIME_W-1:0] pick_interval();
		if ($urandom_range(9) == 0)
			return $urandom;
		return TIME_W'($urandom_range(60));
	endfunction

	// Adds fresh tasks until the table is full, then tries once more with a present key.
	task automatic fill_table();
		logic [KEY_W-1:0] key;
		while (sb.tab_count < MAX_TASKS) begin
			do
				key = pick_key();
			while (sb.find_key(key) >= 0);
			send_request(ACT_ADD, key, pick_interval(), 1'($urandom_range(1)), $urandom);
		end
		send_request(ACT_ADD, sb.tab_key[$urandom_range(MAX_TASKS - 1)], pick_interval(),
			1'($urandom_range(1)), $urandom);
	endtask

	// Full table, every task enabled, and big time steps while the result side is held.
	task automatic pressure_burst();
		fill_table();
		for (int i = 0; i < MAX_TASKS; i++)
			send_request(ACT_ENABLE, sb.tab_key[i], $urandom, 1'($urandom_range(1)), $urandom);
		hold_receiver(300);
		repeat (5) begin
			clock_ms += 32'h4000_0000;
			send_request(ACT_TICK, KEY_W'($urandom), $urandom, 1'($urandom_range(1)),
				clock_ms);
		end
	endtask

	// One random request of any kind.
	task automatic random_request();
		int r;
		r = $urandom_range(99);
		if (r < 20) begin
			send_request(ACT_ADD, pick_key(), pick_interval(), 1'($urandom_range(1)),
				$urandom);
		end else if (r < 37) begin
			send_request(ACT_REMOVE, table_key(), $urandom, 1'($urandom_range(1)), $urandom);
		end else if (r < 52) begin
			send_request($urandom_range(1) ? ACT_ENABLE : ACT_DISABLE, table_key(), $urandom,
				1'($urandom_range(1)), $urandom);
		end else if (r < 92) begin
			if ($urandom_range(15) == 0)
				clock_ms = $urandom;
			else
				clock_ms += $urandom_range(30);
			send_request(ACT_TICK, KEY_W'($urandom), $urandom, 1'($urandom_range(1)),
				clock_ms);
		end else if (r < 94) begin
			fill_table();
		end else begin
			send_request(ACT_W'($urandom_range(ACT_UNDEF_LAST, ACT_UNDEF_FIRST)),
				KEY_W'($urandom), $urandom, 1'($urandom_range(1)), $urandom);
		end
	endtask

	initial begin
		int phase;
		sb = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_ADD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, misses, extreme keys and times, wrap of the elapsed time.
		send_request(ACT_TICK, '0, '0, 1'b0, '0);
		send_request(ACT_REMOVE, 16'd5, '0, 1'b0, '0);
		send_request(ACT_ENABLE, 16'd5, '0, 1'b0, '0);
		send_request(ACT_DISABLE, 16'd5, '0, 1'b0, '0);
		send_request(ACT_ADD, 16'h0000, 32'h0000_0000, 1'b1, '0);
		send_request(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '1);
		send_request(ACT_ADD, 16'h0000, 32'd5, 1'b0, '0);
		send_request(ACT_TICK, '1, '1, 1'b1, 32'hFFFF_FFFF);
		send_request(ACT_ENABLE, 16'hFFFF, '0, 1'b0, '0);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'hFFFF_FFFE);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'hFFFF_FFFF);
		send_request(ACT_DISABLE, 16'h0000, '0, 1'b0, '0);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'd0);
		send_request(ACT_ADD, 16'h1234, 32'd10, 1'b1, '0);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'd9);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'd10);
		send_request(ACT_REMOVE, 16'hFFFF, '0, 1'b0, '0);
		send_request(ACT_TICK, '0, '0, 1'b0, 32'd20);
		send_request(ACT_REMOVE, 16'h0000, '0, 1'b0, '0);
		send_request(ACT_REMOVE, 16'h1234, '0, 1'b0, '0);
		send_request(ACT_UNDEF_FIRST, '1, '1, 1'b1, '1);
		send_request(ACT_UNDEF_FIRST + 3'd1, '0, '0, 1'b0, '0);
		send_request(ACT_UNDEF_LAST, '1, '1, 1'b1, '1);
		send_request(ACT_TICK, '0, '0, 1'b0, '0);

		// Random requests, in three idling phases; the held-off stretch opens the last.
		clock_ms     = 32'd20;
		useful_count = 0;
		phase        = 0;
		while (useful_count < 360) begin
			if (phase == 0 && useful_count >= 120) begin
				phase     = 1;
				send_idle = 49;
				recv_idle <= 38;
			end else if (phase == 1 && useful_count >= 240) begin
				phase     = 2;
				send_idle = 0;
				recv_idle <= 0;
				pressure_burst();
			end
			random_request();
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then allow for anything the block might still send.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
